/* sv/bpd_pkg.sv */
package bpd_pkg;

    // Pixel format: unsigned 8.4 fixed point
    localparam int PIX_W  = 12;
    // One vertical [1 2 1] column sum
    localparam int CSUM_W = PIX_W + 2;
    // Full 3x3 weighted sum (weights total 16)
    localparam int SUM_W  = PIX_W + 4;

    // Geometry registers
    localparam int DIM_W      = 11;
    localparam int MAX_HEIGHT = 1024;
    localparam int ROW_W      = 10;

    localparam logic [DIM_W-1:0] WIDTH_RST  = 11'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 11'd480;

    // Configuration register indexes
    localparam logic CFG_SRC_WIDTH  = 1'b0;
    localparam logic CFG_SRC_HEIGHT = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_in;
        logic             frame_start;
    } t_in;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             frame_end;
    } t_out;

    // Control of the item in the filter stage
    typedef struct packed {
        logic valid;     // item present
        logic odd_row;   // source row is odd
        logic prod;      // item yields an output pixel
        logic last;      // last output pixel of the frame
        logic top_mid;   // first odd row: top row replicates the centre row
        logic left_dup;  // column 1: left column replicates column 0
    } t_s1_ctrl;

endpackage

/* sv/bpd_line_store.sv */
module bpd_line_store #(
    parameter int MAX_WIDTH = 1024,
    parameter int AW        = 10
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_odd_row,
    input  logic [AW-1:0]            i_addr,
    input  logic [bpd_pkg::PIX_W-1:0] i_wdata,
    output logic [bpd_pkg::PIX_W-1:0] o_even_rd,
    output logic [bpd_pkg::PIX_W-1:0] o_odd_rd
);
    import bpd_pkg::*;

    logic [PIX_W-1:0] even_mem [MAX_WIDTH];
    logic [PIX_W-1:0] odd_mem  [MAX_WIDTH];
    logic [PIX_W-1:0] r_even_rd;
    logic [PIX_W-1:0] r_odd_rd;

    // Even rows: centre line for the next odd row
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!i_odd_row) begin
                even_mem[i_addr] <= i_wdata;
            end
            r_even_rd <= even_mem[i_addr];
        end
    end

    // Odd rows: read the previous odd row, then overwrite with this one
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_odd_row) begin
                odd_mem[i_addr] <= i_wdata;
            end
            r_odd_rd <= odd_mem[i_addr];
        end
    end

    assign o_even_rd = r_even_rd;
    assign o_odd_rd  = r_odd_rd;

endmodule

/* sv/bpd_filter.sv */
module bpd_filter (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  bpd_pkg::t_s1_ctrl         i_ctrl,
    input  logic [bpd_pkg::PIX_W-1:0] i_pix,
    input  logic [bpd_pkg::PIX_W-1:0] i_even_rd,
    input  logic [bpd_pkg::PIX_W-1:0] i_odd_rd,
    output logic                      o_push,
    output bpd_pkg::t_out             o_res
);
    import bpd_pkg::*;

    logic [CSUM_W-1:0] r_csum0;   // two columns back
    logic [CSUM_W-1:0] r_csum1;   // one column back
    logic [CSUM_W-1:0] n_csum0;
    logic [CSUM_W-1:0] n_csum1;
    logic [PIX_W-1:0]  top;
    logic [CSUM_W-1:0] vsum;
    logic [CSUM_W-1:0] left;
    logic [SUM_W-1:0]  hsum;
    logic [SUM_W-1:0]  rounded;
    logic              upd;

    // Vertical [1 2 1] over top, centre and current row
    always_comb begin
        top  = i_ctrl.top_mid ? i_even_rd : i_odd_rd;
        vsum = CSUM_W'(top) + {1'b0, i_even_rd, 1'b0} + CSUM_W'(i_pix);
    end

    // Horizontal [1 2 1] over the last three column sums, round half up
    always_comb begin
        left    = i_ctrl.left_dup ? r_csum1 : r_csum0;
        hsum    = SUM_W'(left) + SUM_W'({r_csum1, 1'b0}) + SUM_W'(vsum);
        rounded = hsum + SUM_W'(8);
    end

    assign upd     = i_ctrl.valid && i_ctrl.odd_row;
    assign n_csum0 = upd ? r_csum1 : r_csum0;
    assign n_csum1 = upd ? vsum : r_csum1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_csum0 <= '0;
            r_csum1 <= '0;
        end else begin
            r_csum0 <= n_csum0;
            r_csum1 <= n_csum1;
        end
    end

    assign o_push          = i_ctrl.prod;
    assign o_res.pixel_out = rounded[SUM_W-1:4];
    assign o_res.frame_end = i_ctrl.last;

endmodule

/* sv/bpd_out_fifo.sv */
module bpd_out_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bpd_pkg::t_out i_data,
    input  logic          i_stall,
    output logic          o_valid,
    output bpd_pkg::t_out o_data,
    output logic [1:0]    o_level
);
    import bpd_pkg::*;

    t_out       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_level;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_level;
    logic       pop;

    assign o_valid = (r_level != 2'd0);
    assign o_data  = r_q[r_rd_ptr];
    assign o_level = r_level;
    assign pop     = o_valid && !i_stall;

    // Pointer and fill level update
    always_comb begin
        n_wr_ptr = i_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? !r_rd_ptr : r_rd_ptr;
        n_level  = r_level + {1'b0, i_push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_level  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_level  <= n_level;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* sv/binomial_pyramid_downsample.sv */
// Channel   Direction  Valid    Stall    Payload
// input     in         i_valid  o_stall  i_data  (pixel_in, frame_start)
// output    out        o_valid  i_stall  o_data  (pixel_out, frame_end)
// config    in         i_cfg_we -        i_cfg_idx, i_cfg_data
//
// One source pixel per clock while o_stall is low. The output pixel for a source
// pixel at odd row, odd column is built from the registered line store reads.
// Synchronous active-low reset clears counters and the output queue; the
// geometry returns to 640 x 480. Line stores are not cleared.
// o_stall comes from registers only: it rises when the 2-entry output queue
// and the item in the filter stage would fill it.
module binomial_pyramid_downsample #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  bpd_pkg::t_in              i_data,
    output logic                      o_valid,
    input  logic                      i_stall,
    output bpd_pkg::t_out             o_data,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [bpd_pkg::DIM_W-1:0] i_cfg_data
);
    import bpd_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int CW = ((WW > DIM_W) ? WW : DIM_W) + 1;
    localparam int HW = DIM_W + 1;

    logic [DIM_W-1:0] r_width_cfg;
    logic [DIM_W-1:0] r_height_cfg;
    logic [AW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic [AW-1:0]    n_col;
    logic [ROW_W-1:0] n_row;
    t_s1_ctrl         r_s1;
    t_s1_ctrl         n_s1;
    logic [PIX_W-1:0] r_s1_pix;

    logic             accept;
    logic [CW-1:0]    w;
    logic [HW-1:0]    h;
    logic [CW-1:0]    col_x;
    logic [HW-1:0]    row_x;
    logic [AW-1:0]    col;
    logic [ROW_W-1:0] row;
    logic [CW-1:0]    last_col;
    logic [HW-1:0]    last_row;
    logic [PIX_W-1:0] even_rd;
    logic [PIX_W-1:0] odd_rd;
    logic             push;
    t_out             res;
    logic [1:0]       level;
    logic [2:0]       pending;

    // Geometry registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_cfg  <= WIDTH_RST;
            r_height_cfg <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_SRC_WIDTH) begin
                r_width_cfg <= i_cfg_data;
            end
            if (i_cfg_idx == CFG_SRC_HEIGHT) begin
                r_height_cfg <= i_cfg_data;
            end
        end
    end

    // Saturated geometry
    always_comb begin
        w = CW'(r_width_cfg);
        if (w < CW'(2)) begin
            w = CW'(2);
        end else if (w > CW'(MAX_WIDTH)) begin
            w = CW'(MAX_WIDTH);
        end
        h = HW'(r_height_cfg);
        if (h < HW'(2)) begin
            h = HW'(2);
        end else if (h > HW'(MAX_HEIGHT)) begin
            h = HW'(MAX_HEIGHT);
        end
        last_col = {w[CW-1:1], 1'b0} - CW'(1);
        last_row = {h[HW-1:1], 1'b0} - HW'(1);
    end

    // Input handshake
    assign pending = {1'b0, level} + {2'b0, r_s1.prod};
    assign o_stall = (pending >= 3'd2);
    assign accept  = i_valid && !o_stall;

    // Position of the current pixel and the next one
    always_comb begin
        col   = i_data.frame_start ? '0 : r_col;
        row   = i_data.frame_start ? '0 : r_row;
        col_x = CW'(col);
        row_x = HW'(row);
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (col_x + CW'(1) >= w) begin
                n_col = '0;
                n_row = (row_x + HW'(1) >= h) ? '0 : row + ROW_W'(1);
            end else begin
                n_col = col + AW'(1);
                n_row = row;
            end
        end
    end

    // Filter stage control
    always_comb begin
        n_s1.valid    = accept;
        n_s1.odd_row  = row[0];
        n_s1.prod     = accept && row[0] && col[0] && (col_x < w) && (row_x < h);
        n_s1.last     = (col_x == last_col) && (row_x == last_row);
        n_s1.top_mid  = (row == ROW_W'(1));
        n_s1.left_dup = (col == AW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_s1  <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_s1  <= n_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix <= i_data.pixel_in;
        end
    end

    bpd_line_store #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_en      (accept),
        .i_odd_row (row[0]),
        .i_addr    (col),
        .i_wdata   (i_data.pixel_in),
        .o_even_rd (even_rd),
        .o_odd_rd  (odd_rd)
    );

    bpd_filter u_filter (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (r_s1),
        .i_pix     (r_s1_pix),
        .i_even_rd (even_rd),
        .i_odd_rd  (odd_rd),
        .o_push    (push),
        .o_res     (res)
    );

    bpd_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (res),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .o_level (level)
    );

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
    import bpd_pkg::*;

    localparam int LINE_MAX = 1024;

    // DUT ports
    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             i_valid    = 1'b0;
    logic             o_stall;
    t_in              i_data     = '0;
    logic             o_valid;
    logic             i_stall    = 1'b0;
    t_out             o_data;
    logic             i_cfg_we   = 1'b0;
    logic             i_cfg_idx  = CFG_SRC_WIDTH;
    logic [DIM_W-1:0] i_cfg_data = '0;

    // Source requests waiting to be driven, reduced pixels waiting to come out
    t_in  src_pixels_q[$];
    t_out reduced_q[$];
    t_out want_px;

    // Bookkeeping
    int n_sent     = 0;
    int n_checked  = 0;
    int n_errors   = 0;
    int n_settings = 0;

    // Idle bursts: percent chances of starting a gap or a stall burst, remaining cycles of the burst
    int gap_pct    = 0;
    int stall_pct  = 0;
    int gap_left   = 0;
    int stall_left = 0;

    // Shadow of the block: geometry registers, line stores, column sums, position
    logic [DIM_W-1:0]  width_reg  = WIDTH_RST;
    logic [DIM_W-1:0]  height_reg = HEIGHT_RST;
    logic [PIX_W-1:0]  odd_line  [LINE_MAX];
    logic [PIX_W-1:0]  even_line [LINE_MAX];
    logic [CSUM_W-1:0] vsum_two   = '0;
    logic [CSUM_W-1:0] vsum_one   = '0;
    int unsigned       col_pos    = 0;
    int unsigned       row_pos    = 0;

    binomial_pyramid_downsample #(
        .MAX_WIDTH(LINE_MAX)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Out-of-range geometry saturates to 2..hi
    function automatic int unsigned fit_dim(logic [DIM_W-1:0] v, int unsigned hi);
        if (v < 2) return 2;
        if (v > hi) return hi;
        return v;
    endfunction

    // One source pixel through the reduce stage; queues the output pixel it makes
    function automatic void reduce_pixel(t_in req);
        int unsigned w, h, c, r, mid, top, vs, left, sum;
        t_out res;
        w = fit_dim(width_reg, LINE_MAX);
        h = fit_dim(height_reg, MAX_HEIGHT);
        if (req.frame_start) begin
            col_pos = 0;
            row_pos = 0;
        end
        c = col_pos;
        r = row_pos;
        if (c < LINE_MAX) begin
            if ((r & 1) == 0) begin
                even_line[c] = req.pixel_in;
            end else begin
                // vertical [1 2 1]; first odd row replicates the top edge
                mid = even_line[c];
                top = (r == 1) ? mid : odd_line[c];
                vs  = top + 2 * mid + req.pixel_in;
                if ((c & 1) == 1 && c < w && r < h) begin
                    // horizontal [1 2 1]; column 1 replicates the left edge
                    left = (c == 1) ? vsum_one : vsum_two;
                    sum  = left + 2 * vsum_one + vs;
                    res.pixel_out = PIX_W'((sum + 8) >> 4);
                    res.frame_end = (c == 2 * (w / 2) - 1) && (r == 2 * (h / 2) - 1);
                    reduced_q = {reduced_q, res};
                end
                vsum_two = vsum_one;
                vsum_one = CSUM_W'(vs);
                odd_line[c] = req.pixel_in;
            end
        end
        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endfunction

    // Source side: drive pending requests, predict on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                reduce_pixel(i_data);
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (src_pixels_q.size() > 0) begin
                    i_valid <= 1'b1;
                    i_data  <= src_pixels_q.pop_front();
                    if ($urandom_range(0, 99) < gap_pct) begin
                        gap_left = $urandom_range(1, 10);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result side: random stall bursts, check each accepted pixel
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (reduced_q.size() == 0) begin
                    n_errors++;
                    $error("unexpected output pixel %0d", o_data.pixel_out);
                end else begin
                    want_px = reduced_q.pop_front();
                    n_checked++;
                    if (o_data.pixel_out !== want_px.pixel_out) begin
                        n_errors++;
                        $error("pixel_out: expected %0d, got %0d",
                               want_px.pixel_out, o_data.pixel_out);
                    end
                    if (o_data.frame_end !== want_px.frame_end) begin
                        n_errors++;
                        $error("frame_end: expected %0d, got %0d",
                               want_px.frame_end, o_data.frame_end);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if ($urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(1, 10) - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    function automatic void push_px(logic [PIX_W-1:0] p, logic s);
        t_in req;
        req.pixel_in    = p;
        req.frame_start = s;
        src_pixels_q = {src_pixels_q, req};
        n_sent++;
    endfunction

    // Mostly uniform, with extremes, low values that hit the rounding edge and values near full scale
    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return PIX_W'($urandom_range(0, 15));
            3: return PIX_W'(4095 - $urandom_range(0, 15));
            default: return PIX_W'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 7))
            0: return DIM_W'(0);
            1: return DIM_W'(1);
            2: return DIM_W'(2);
            3: return DIM_W'(3);
            default: return DIM_W'($urandom_range(2, 16));
        endcase
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 5;
            2: return 20;
            default: return 50;
        endcase
    endfunction

    // Raster stream at the current geometry; first request always starts a frame.
    // Frame boundaries get frame_start at random (otherwise the position wraps);
    // with noise, a frame is occasionally restarted midway.
    function automatic void queue_frames(int n, bit noise);
        int unsigned w, h, c, r;
        logic        s;
        w = fit_dim(width_reg, LINE_MAX);
        h = fit_dim(height_reg, MAX_HEIGHT);
        c = 0;
        r = 0;
        for (int k = 0; k < n; k++) begin
            if (k == 0) begin
                s = 1'b1;
            end else if (c == 0 && r == 0) begin
                s = 1'($urandom_range(0, 1));
            end else begin
                s = noise && ($urandom_range(0, 79) == 0);
            end
            if (s) begin
                c = 0;
                r = 0;
            end
            push_px(pick_pixel(), s);
            if (c + 1 >= w) begin
                c = 0;
                r = (r + 1 >= h) ? 0 : r + 1;
            end else begin
                c++;
            end
        end
    endfunction

    // Wait until every request is taken and every pixel has come out, plus pipeline slack
    task automatic wait_drained();
        @(negedge i_clk);
        while (src_pixels_q.size() != 0 || i_valid || reduced_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_geometry(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
        wait_drained();
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_SRC_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_SRC_HEIGHT;
        i_cfg_data <= h;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        width_reg  = w;
        height_reg = h;
        n_settings++;
        gap_pct    = pick_pct();
        stall_pct  = pick_pct();
    endtask

    // Main sequence
    initial begin
        int n;
        int unsigned area;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: full-scale 4x4 frame, then a frame that begins by wrapping
        set_geometry(DIM_W'(4), DIM_W'(4));
        gap_pct   = 0;
        stall_pct = 0;
        for (int k = 0; k < 16; k++) begin
            push_px('1, k == 0);
        end
        push_px(12'd0, 1'b0);
        push_px(12'd1, 1'b0);
        push_px(12'd4095, 1'b0);
        push_px(12'd8, 1'b0);
        push_px(12'd7, 1'b0);
        push_px(12'd4095, 1'b0);
        push_px(12'd0, 1'b0);
        push_px(12'd9, 1'b0);

        // Geometry extremes: tall, saturated height, saturated width
        set_geometry(DIM_W'(2), DIM_W'(1024));
        queue_frames(24, 1'b0);
        set_geometry(DIM_W'(5), DIM_W'(2047));
        queue_frames(20, 1'b0);
        set_geometry(DIM_W'(2047), DIM_W'(2));
        queue_frames(LINE_MAX + 4, 1'b0);

        // Random small geometries, register values below the minimum included
        while (n_sent < 1180) begin
            set_geometry(pick_dim(), pick_dim());
            area = fit_dim(width_reg, LINE_MAX) * fit_dim(height_reg, MAX_HEIGHT);
            n = $urandom_range(1, 2) * area + $urandom_range(0, area / 2);
            if (n > 40) n = 40;
            queue_frames(n, 1'b1);
        end

        // Closing stretch at full rate
        set_geometry(DIM_W'($urandom_range(2, 6)), DIM_W'($urandom_range(2, 6)));
        gap_pct   = 0;
        stall_pct = 0;
        area = fit_dim(width_reg, LINE_MAX) * fit_dim(height_reg, MAX_HEIGHT);
        queue_frames(2 * area + 3, 1'b1);

        wait_drained();
        $display("Sent %0d source pixels over %0d geometry settings, checked %0d reduced pixels",
                 n_sent, n_settings, n_checked);
        $display("Covered 2x2 to saturated 1024-wide/high frames, odd edges, restarts, stalls");
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

/* files.f */
sv/bpd_pkg.sv
sv/bpd_line_store.sv
sv/bpd_filter.sv
sv/bpd_out_fifo.sv
sv/binomial_pyramid_downsample.sv
tb/tb.sv
